@@ hw/rtl/fbpa_pkg.sv @@
package fbpa_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 13;
  localparam int COUNT_W = 9;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 3;
  localparam int REG_W   = 2;
  localparam int CFG_W   = 32;

  // Largest block size accepted before rounding
  localparam int SIZE_MAX = 4096;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_NULL_ADDR   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DOUBLE_INIT = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_INIT    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ALL_FREE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_POOL_EMPTY  = 3'd5;
  localparam logic [STAT_W-1:0] ST_OUT_OF_POOL = 3'd6;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [REG_W-1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [REG_W-1:0] REG_BLOCK_COUNT = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              op_load;    // capture free offset
    logic              init_load;  // latch configuration
    logic              init_quot;  // size quotient by word
    logic              init_size;  // rounded block size
    logic              init_span;  // pool span in bytes
    logic              link_step;  // write one link of the initial list
    logic              init_done;  // finish init
    logic              div_start;  // start offset division
    logic              pop;        // take the head block
    logic              push;       // return a block to the head
    logic              emit;       // present a result beat
    logic [STAT_W-1:0] status;
  } fbpa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic initialized;
    logic addr_zero;
    logic none_free;
    logic all_free;
    logic out_of_span;
    logic link_last;
    logic div_done;
    logic div_rem_zero;
  } fbpa_stat_t;

endpackage

@@ hw/rtl/fbpa_div.sv @@
module fbpa_div #(
  parameter int DVS_W = 13,
  parameter int QUO_W = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DVS_W+QUO_W-2:0] dividend,
  input  logic [DVS_W-1:0]       divisor,
  output logic                   done,
  output logic [QUO_W-1:0]       quotient,
  output logic                   rem_zero
);

  localparam int DVD_W  = DVS_W + QUO_W - 1;
  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [DVD_W-1:0]  rem;
  logic [DVD_W-1:0]  dsr;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] steps;
  logic              fits;

  assign fits = (rem >= dsr);

  // Count restoring steps, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1));
      if (start) begin
        steps <= STEP_W'(QUO_W);
      end else if (steps != '0) begin
        steps <= steps - STEP_W'(1);
      end
    end
  end

  // Subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsr <= {divisor, {(QUO_W-1){1'b0}}};
    end else if (steps != '0) begin
      if (fits) begin
        rem <= rem - dsr;
      end
      quo <= {quo[QUO_W-2:0], fits};
      dsr <= dsr >> 1;
    end
  end

  assign quotient = quo;
  assign rem_zero = (rem == '0);

endmodule

@@ hw/rtl/fbpa_dp.sv @@
module fbpa_dp #(
  parameter int MAX_BLOCKS = 256,
  parameter int WORD_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fbpa_pkg::REG_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [fbpa_pkg::ADDR_W-1:0]   block_addr,
  input  fbpa_pkg::fbpa_cmd_t           cmd,
  output fbpa_pkg::fbpa_stat_t          stat,
  output logic                          done,
  output logic [fbpa_pkg::STAT_W-1:0]   status,
  output logic [fbpa_pkg::ADDR_W-1:0]   alloc_addr,
  output logic [fbpa_pkg::COUNT_W-1:0]  free_count
);

  localparam int IW      = $clog2(MAX_BLOCKS);
  localparam int CW      = fbpa_pkg::COUNT_W;
  localparam int ZW      = fbpa_pkg::SIZE_W;
  localparam int AW      = fbpa_pkg::ADDR_W;
  localparam int SW      = ZW + CW - 1;
  localparam int RSHIFT  = 20;
  localparam int RECIP_W = RSHIFT + 1;
  localparam int RECIP   = ((1 << RSHIFT) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int CMPW    = (IW + 1 > CW) ? IW + 1 : CW;

  // Configuration registers
  logic [AW-1:0] cfg_base;
  logic [ZW-1:0] cfg_bytes;
  logic [CW-1:0] cfg_count;

  // Pool state
  logic [AW-1:0] held_base;
  logic [CW-1:0] held_count;
  logic [ZW-1:0] rsize;
  logic [SW-1:0] span;
  logic [IW-1:0] head;
  logic [CW-1:0] blocks_free;
  logic [CW-1:0] blocks_free_next;
  logic          initialized;
  logic [IW-1:0] link_i;

  // Working registers
  logic [ZW-1:0] round_in_q;
  logic [ZW-1:0] quot;
  logic [AW-1:0] off_q;
  logic [AW-1:0] prod;
  logic [IW-1:0] rd_link;

  // Link memory
  logic [IW-1:0] link_mem [MAX_BLOCKS];

  logic [ZW-1:0]         req_clamped;
  logic [CW-1:0]         cnt_clamped;
  logic [ZW-1:0]         round_in;
  logic [ZW+RECIP_W-1:0] recip_prod;
  logic [ZW+3:0]         size_prod;
  logic [CW+ZW-1:0]      span_prod;
  logic [IW+ZW-1:0]      addr_prod;
  logic [CW+IW-1:0]      quot_ext;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         link_val;
  logic                  link_we;
  logic [IW-1:0]         link_waddr;
  logic [IW-1:0]         link_wdata;
  logic [CW-1:0]         div_quot;
  logic                  div_done;
  logic                  div_rem_zero;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base  <= '0;
      cfg_bytes <= ZW'(4);
      cfg_count <= CW'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fbpa_pkg::REG_POOL_BASE:   cfg_base  <= cfg_wdata[AW-1:0];
        fbpa_pkg::REG_BLOCK_BYTES: cfg_bytes <= cfg_wdata[ZW-1:0];
        fbpa_pkg::REG_BLOCK_COUNT: cfg_count <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp requested size and count
  always_comb begin
    if (cfg_bytes == '0) begin
      req_clamped = ZW'(1);
    end else if (int'(cfg_bytes) > fbpa_pkg::SIZE_MAX) begin
      req_clamped = ZW'(fbpa_pkg::SIZE_MAX);
    end else begin
      req_clamped = cfg_bytes;
    end
    if (cfg_count == '0) begin
      cnt_clamped = CW'(1);
    end else if (int'(cfg_count) > MAX_BLOCKS) begin
      cnt_clamped = CW'(MAX_BLOCKS);
    end else begin
      cnt_clamped = cfg_count;
    end
  end

  assign round_in   = req_clamped + ZW'(WORD_BYTES - 1);
  assign recip_prod = round_in_q * RECIP_W'(RECIP);
  assign size_prod  = quot * 4'(WORD_BYTES);
  assign span_prod  = held_count * rsize;
  assign addr_prod  = head * rsize;

  // Quotient index of a freed block
  assign quot_ext = {{IW{1'b0}}, div_quot};
  assign free_idx = quot_ext[IW-1:0];

  // Link of the current block during the initial walk
  assign link_val = stat.link_last ? '0 : link_i + IW'(1);

  // Pick the link write source
  assign link_we    = cmd.link_step | cmd.push;
  assign link_waddr = cmd.link_step ? link_i : free_idx;
  assign link_wdata = cmd.link_step ? link_val : head;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_link <= link_mem[head];
  end

  // Next free count
  always_comb begin
    priority if (cmd.init_done) begin
      blocks_free_next = held_count;
    end else if (cmd.pop) begin
      blocks_free_next = blocks_free - CW'(1);
    end else if (cmd.push) begin
      blocks_free_next = blocks_free + CW'(1);
    end else begin
      blocks_free_next = blocks_free;
    end
  end

  // Update pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_base   <= '0;
      held_count  <= '0;
      rsize       <= '0;
      head        <= '0;
      blocks_free <= '0;
      initialized <= 1'b0;
      link_i      <= '0;
      done        <= 1'b0;
    end else begin
      if (cmd.init_load) begin
        held_base  <= cfg_base;
        held_count <= cnt_clamped;
        link_i     <= '0;
      end
      if (cmd.init_size) begin
        rsize <= size_prod[ZW-1:0];
      end
      if (cmd.link_step) begin
        link_i <= link_i + IW'(1);
      end
      priority if (cmd.init_done) begin
        head <= '0;
      end else if (cmd.pop) begin
        head <= rd_link;
      end else if (cmd.push) begin
        head <= free_idx;
      end
      blocks_free <= blocks_free_next;
      if (cmd.init_done) begin
        initialized <= 1'b1;
      end
      done <= cmd.emit;
    end
  end

  // Hold working values and the result beat
  always_ff @(posedge clk) begin
    if (cmd.init_load) begin
      round_in_q <= round_in;
    end
    if (cmd.init_quot) begin
      quot <= recip_prod[RSHIFT +: ZW];
    end
    if (cmd.init_span) begin
      span <= span_prod[SW-1:0];
    end
    if (cmd.op_load) begin
      off_q <= block_addr - held_base;
    end
    prod <= AW'(addr_prod);
    if (cmd.emit) begin
      status     <= cmd.status;
      alloc_addr <= cmd.pop ? held_base + prod : '0;
      free_count <= blocks_free_next;
    end
  end

  fbpa_div #(
    .DVS_W (ZW),
    .QUO_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (off_q[SW-1:0]),
    .divisor  (rsize),
    .done     (div_done),
    .quotient (div_quot),
    .rem_zero (div_rem_zero)
  );

  // Report status to the controller
  always_comb begin
    stat.initialized  = initialized;
    stat.addr_zero    = (block_addr == '0);
    stat.none_free    = (blocks_free == '0);
    stat.all_free     = (blocks_free >= held_count);
    stat.out_of_span  = (off_q >= AW'(span));
    stat.link_last    = ((CMPW'(link_i) + CMPW'(1)) == CMPW'(held_count));
    stat.div_done     = div_done;
    stat.div_rem_zero = div_rem_zero;
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    blocks_free <= held_count)
    else $error("free count above pool size");

  a_init_sticky: assert property (@(posedge clk) disable iff (rst)
    initialized |=> initialized)
    else $error("pool lost its init state");

  a_link_range: assert property (@(posedge clk) disable iff (rst)
    cmd.link_step |-> (CMPW'(link_i) < CMPW'(held_count)))
    else $error("link walk beyond pool");

endmodule

@@ hw/rtl/fbpa_ctrl.sv @@
module fbpa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fbpa_pkg::FUNC_W-1:0] func,
  input  fbpa_pkg::fbpa_stat_t        stat,
  output logic                        busy,
  output fbpa_pkg::fbpa_cmd_t         cmd
);

  localparam int STATE_W = 3;

  localparam logic [STATE_W-1:0] S_IDLE      = 3'd0;
  localparam logic [STATE_W-1:0] S_INIT_Q    = 3'd1;
  localparam logic [STATE_W-1:0] S_INIT_SZ   = 3'd2;
  localparam logic [STATE_W-1:0] S_INIT_SPAN = 3'd3;
  localparam logic [STATE_W-1:0] S_INIT_LINK = 3'd4;
  localparam logic [STATE_W-1:0] S_ALLOC     = 3'd5;
  localparam logic [STATE_W-1:0] S_FREE_CHK  = 3'd6;
  localparam logic [STATE_W-1:0] S_FREE_DIV  = 3'd7;

  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;

  assign busy = (state != S_IDLE);

  // Decode the item and sequence its steps
  always_comb begin
    cmd        = '0;
    cmd.status = fbpa_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (func)
            fbpa_pkg::FUNC_INIT: begin
              if (stat.initialized) begin
                cmd.emit   = 1'b1;
                cmd.status = fbpa_pkg::ST_DOUBLE_INIT;
              end else begin
                cmd.init_load = 1'b1;
                state_next    = S_INIT_Q;
              end
            end
            fbpa_pkg::FUNC_ALLOC: begin
              priority if (!stat.initialized) begin
                cmd.emit   = 1'b1;
                cmd.status = fbpa_pkg::ST_NOT_INIT;
              end else if (stat.none_free) begin
                cmd.emit   = 1'b1;
                cmd.status = fbpa_pkg::ST_POOL_EMPTY;
              end else begin
                state_next = S_ALLOC;
              end
            end
            fbpa_pkg::FUNC_FREE: begin
              cmd.op_load = 1'b1;
              priority if (stat.addr_zero) begin
                cmd.emit   = 1'b1;
                cmd.status = fbpa_pkg::ST_NULL_ADDR;
              end else if (!stat.initialized) begin
                cmd.emit   = 1'b1;
                cmd.status = fbpa_pkg::ST_NOT_INIT;
              end else if (stat.all_free) begin
                cmd.emit   = 1'b1;
                cmd.status = fbpa_pkg::ST_ALL_FREE;
              end else begin
                state_next = S_FREE_CHK;
              end
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_INIT_Q: begin
        cmd.init_quot = 1'b1;
        state_next    = S_INIT_SZ;
      end
      S_INIT_SZ: begin
        cmd.init_size = 1'b1;
        state_next    = S_INIT_SPAN;
      end
      S_INIT_SPAN: begin
        cmd.init_span = 1'b1;
        state_next    = S_INIT_LINK;
      end
      S_INIT_LINK: begin
        cmd.link_step = 1'b1;
        if (stat.link_last) begin
          cmd.init_done = 1'b1;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ALLOC: begin
        cmd.pop    = 1'b1;
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_FREE_CHK: begin
        if (stat.out_of_span) begin
          cmd.emit   = 1'b1;
          cmd.status = fbpa_pkg::ST_OUT_OF_POOL;
          state_next = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_FREE_DIV;
        end
      end
      S_FREE_DIV: begin
        if (stat.div_done) begin
          cmd.emit = 1'b1;
          if (stat.div_rem_zero) begin
            cmd.push = 1'b1;
          end else begin
            cmd.status = fbpa_pkg::ST_OUT_OF_POOL;
          end
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> ##(fbpa_pkg::COUNT_W + 1) stat.div_done)
    else $error("divider finished off schedule");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.none_free)
    else $error("pop from an empty list");

endmodule

@@ hw/rtl/fixed_block_pool_allocator.sv @@
// Channel   Ports                                   Beat taken when
// -------   -------------------------------------   -------------------------
// item in   start, busy, func, block_addr           start high and busy low
// result    done, status, alloc_addr, free_count    done high (one cycle)
// config    cfg_wr_en, cfg_index, cfg_wdata         cfg_wr_en high
//
// Each item gives one result beat on the cycle after its last step; busy is
// low in that cycle, so the next item may be taken there.
// Errors and unused codes are answered from idle; allocate waits for the link
// memory read and index-times-size product; a free beyond the pool span ends
// at the span check; any other free runs the 9-step restoring divider; init
// writes one link per cycle. Synchronous reset; no memory clearing pass.
// The receiver cannot stall; results are never held back.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 256,
  parameter int WORD_BYTES = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [fbpa_pkg::FUNC_W-1:0]  func,
  input  logic [fbpa_pkg::ADDR_W-1:0]  block_addr,
  input  logic                         cfg_wr_en,
  input  logic [fbpa_pkg::REG_W-1:0]   cfg_index,
  input  logic [fbpa_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                         done,
  output logic [fbpa_pkg::STAT_W-1:0]  status,
  output logic [fbpa_pkg::ADDR_W-1:0]  alloc_addr,
  output logic [fbpa_pkg::COUNT_W-1:0] free_count
);

  fbpa_pkg::fbpa_cmd_t  cmd;
  fbpa_pkg::fbpa_stat_t stat;
  logic                 item_start;

  // Take a new item only while idle
  assign item_start = start & ~busy;

  fbpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (item_start),
    .func  (func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .block_addr (block_addr),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .status     (status),
    .alloc_addr (alloc_addr),
    .free_count (free_count)
  );

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS  = 256;
  localparam int WORD_BYTES  = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 500;

  // Selector with no operation behind it
  localparam logic [fbpa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [fbpa_pkg::STAT_W-1:0]  status;
    logic [fbpa_pkg::ADDR_W-1:0]  alloc_addr;
    logic [fbpa_pkg::COUNT_W-1:0] free_count;
  } pool_result_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [fbpa_pkg::FUNC_W-1:0]  func;
  logic [fbpa_pkg::ADDR_W-1:0]  block_addr;
  logic                         cfg_wr_en;
  logic [fbpa_pkg::REG_W-1:0]   cfg_index;
  logic [fbpa_pkg::CFG_W-1:0]   cfg_wdata;
  logic                         done;
  logic [fbpa_pkg::STAT_W-1:0]  status;
  logic [fbpa_pkg::ADDR_W-1:0]  alloc_addr;
  logic [fbpa_pkg::COUNT_W-1:0] free_count;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .WORD_BYTES(WORD_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .block_addr(block_addr),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .status(status),
    .alloc_addr(alloc_addr),
    .free_count(free_count)
  );

  // Register shadows, written through the config port
  logic [fbpa_pkg::ADDR_W-1:0]  cfg_base  = '0;
  logic [fbpa_pkg::SIZE_W-1:0]  cfg_bytes = 13'd4;
  logic [fbpa_pkg::COUNT_W-1:0] cfg_count = 9'd1;

  // Pool state as the allocator should hold it
  logic [7:0]                   link_mem [MAX_BLOCKS];
  logic [7:0]                   head = '0;
  logic [fbpa_pkg::COUNT_W-1:0] nfree = '0;
  bit                           ready = 1'b0;
  logic [fbpa_pkg::SIZE_W-1:0]  rsize = '0;
  logic [fbpa_pkg::ADDR_W-1:0]  lbase = '0;
  logic [fbpa_pkg::COUNT_W-1:0] lcount = '0;

  pool_result_t                 awaited_results[$];
  logic [fbpa_pkg::ADDR_W-1:0]  live_blocks[$];
  int                           fail_count = 0;
  int                           cycles = 0;
  int unsigned                  burst_left = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Apply one item to the pool state and return the beat it should produce
  function automatic pool_result_t pool_apply(logic [fbpa_pkg::FUNC_W-1:0] f,
                                              logic [fbpa_pkg::ADDR_W-1:0] a);
    pool_result_t r;
    logic [fbpa_pkg::ADDR_W-1:0] off;
    int unsigned req;
    int unsigned cnt;
    int unsigned idx;
    r = '0;
    r.status = fbpa_pkg::ST_OK;
    case (f)
      fbpa_pkg::FUNC_INIT: begin
        if (ready) begin
          r.status = fbpa_pkg::ST_DOUBLE_INIT;
        end else begin
          req = cfg_bytes;
          cnt = cfg_count;
          if (req == 0) req = 1;
          if (req > fbpa_pkg::SIZE_MAX) req = fbpa_pkg::SIZE_MAX;
          if (cnt == 0) cnt = 1;
          if (cnt > MAX_BLOCKS) cnt = MAX_BLOCKS;
          rsize  = fbpa_pkg::SIZE_W'(((req + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES);
          lbase  = cfg_base;
          lcount = fbpa_pkg::COUNT_W'(cnt);
          // Link blocks in address order, last one back to zero
          for (int i = 0; i < cnt; i++)
            link_mem[i] = (i + 1 < cnt) ? 8'(i + 1) : 8'd0;
          head  = '0;
          nfree = fbpa_pkg::COUNT_W'(cnt);
          ready = 1'b1;
        end
      end
      fbpa_pkg::FUNC_ALLOC: begin
        if (!ready) begin
          r.status = fbpa_pkg::ST_NOT_INIT;
        end else if (nfree == 0) begin
          r.status = fbpa_pkg::ST_POOL_EMPTY;
        end else begin
          r.alloc_addr = lbase + head * rsize;
          head = link_mem[head];
          nfree--;
        end
      end
      fbpa_pkg::FUNC_FREE: begin
        if (a == 0) begin
          r.status = fbpa_pkg::ST_NULL_ADDR;
        end else if (!ready) begin
          r.status = fbpa_pkg::ST_NOT_INIT;
        end else if (nfree >= lcount) begin
          r.status = fbpa_pkg::ST_ALL_FREE;
        end else begin
          off = a - lbase;
          if (off % rsize != 0 || off / rsize >= lcount) begin
            r.status = fbpa_pkg::ST_OUT_OF_POOL;
          end else begin
            idx = off / rsize;
            link_mem[8'(idx)] = head;
            head = 8'(idx);
            nfree++;
          end
        end
      end
      default: ;
    endcase
    r.free_count = nfree;
    return r;
  endfunction

  // Compare each result beat against the oldest awaited one
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual status %0d addr %08h free %0d",
                 $time, status, alloc_addr, free_count);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, status);
          fail_count++;
        end
        if (alloc_addr !== want.alloc_addr) begin
          $display("%0t: alloc_addr mismatch: expected %08h, actual %08h",
                   $time, want.alloc_addr, alloc_addr);
          fail_count++;
        end
        if (free_count !== want.free_count) begin
          $display("%0t: free_count mismatch: expected %0d, actual %0d",
                   $time, want.free_count, free_count);
          fail_count++;
        end
      end
    end
  end

  // Send one item beat; bursts of random length with idle gaps between them
  task automatic send_item(input logic [fbpa_pkg::FUNC_W-1:0] f,
                           input logic [fbpa_pkg::ADDR_W-1:0] a);
    pool_result_t r;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    start      <= 1'b1;
    func       <= f;
    block_addr <= a;
    do @(posedge clk); while (busy);
    r = pool_apply(f, a);
    awaited_results.push_back(r);
    if (f == fbpa_pkg::FUNC_ALLOC && r.status == fbpa_pkg::ST_OK) begin
      live_blocks.push_back(r.alloc_addr);
    end
  endtask

  // Drop start and hold until every awaited beat has come back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fbpa_pkg::REG_W-1:0] idx,
                           input logic [fbpa_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      fbpa_pkg::REG_POOL_BASE:   cfg_base  = data;
      fbpa_pkg::REG_BLOCK_BYTES: cfg_bytes = data[fbpa_pkg::SIZE_W-1:0];
      fbpa_pkg::REG_BLOCK_COUNT: cfg_count = data[fbpa_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Every operation before init, with register extremes written
  task automatic test_before_init();
    write_reg(fbpa_pkg::REG_POOL_BASE, 32'hFFFF_FFFF);
    write_reg(fbpa_pkg::REG_BLOCK_BYTES, 32'd0);
    write_reg(fbpa_pkg::REG_BLOCK_COUNT, 32'd0);
    send_item(fbpa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF);
    send_item(fbpa_pkg::FUNC_FREE, 32'd0);
    send_item(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFFF);
    send_item(fbpa_pkg::FUNC_FREE, $urandom | 32'd1);
    send_item(FUNC_UNUSED, $urandom);
    settle();
    write_reg(fbpa_pkg::REG_BLOCK_BYTES, 32'd8191);
    write_reg(fbpa_pkg::REG_BLOCK_COUNT, 32'd511);
  endtask

  // Pick a pool shape (extremes included), init it, then try to init again
  task automatic test_init_and_repeat();
    logic [fbpa_pkg::SIZE_W-1:0]  bytes;
    logic [fbpa_pkg::COUNT_W-1:0] cnt;
    logic [fbpa_pkg::ADDR_W-1:0]  base;
    int unsigned eff_bytes;
    int unsigned eff_cnt;
    int unsigned rs;
    int unsigned k;
    case ($urandom_range(0, 5))
      0: bytes = 13'd0;
      1: bytes = 13'd8191;
      2: bytes = 13'd4096;
      3: bytes = fbpa_pkg::SIZE_W'($urandom_range(1, 4096));
      default: bytes = fbpa_pkg::SIZE_W'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 6))
      0: cnt = 9'd0;
      1: cnt = 9'd511;
      2: cnt = 9'd256;
      3: cnt = 9'd1;
      default: cnt = fbpa_pkg::COUNT_W'($urandom_range(2, 24));
    endcase
    eff_bytes = (bytes == 0) ? 1 : (bytes > fbpa_pkg::SIZE_MAX) ? fbpa_pkg::SIZE_MAX : bytes;
    eff_cnt   = (cnt == 0) ? 1 : (cnt > MAX_BLOCKS) ? MAX_BLOCKS : cnt;
    rs = ((eff_bytes + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
    case ($urandom_range(0, 3))
      0: base = '0;
      // With two or more blocks, put one exactly at address zero so the pool wraps
      1: begin
        k = (eff_cnt > 1) ? $urandom_range(1, eff_cnt - 1) : 1;
        base = 32'd0 - k * rs;
      end
      2: base = 32'hFFFF_FFFC;
      default: base = $urandom & ~32'd3;
    endcase
    write_reg(fbpa_pkg::REG_POOL_BASE, base);
    write_reg(fbpa_pkg::REG_BLOCK_BYTES, {19'd0, bytes});
    write_reg(fbpa_pkg::REG_BLOCK_COUNT, {23'd0, cnt});
    send_item(fbpa_pkg::FUNC_INIT, $urandom);
    send_item(fbpa_pkg::FUNC_FREE, lbase + rsize);
    send_item(fbpa_pkg::FUNC_FREE, 32'd0);
    settle();
    write_reg(fbpa_pkg::REG_BLOCK_COUNT, 32'd2);
    write_reg(fbpa_pkg::REG_BLOCK_BYTES, 32'd4096);
    write_reg(fbpa_pkg::REG_POOL_BASE, 32'd0);
    send_item(fbpa_pkg::FUNC_INIT, $urandom);
    settle();
  endtask

  // Allocate, free good and foreign addresses, unused selector
  task automatic test_directed_ops();
    repeat (3) send_item(fbpa_pkg::FUNC_ALLOC, $urandom);
    settle();
    if (live_blocks.size() != 0) send_item(fbpa_pkg::FUNC_FREE, live_blocks.pop_front());
    send_item(fbpa_pkg::FUNC_FREE, lbase + rsize + 32'd2);
    send_item(fbpa_pkg::FUNC_FREE, lbase + lcount * rsize);
    send_item(fbpa_pkg::FUNC_FREE, lbase - rsize);
    send_item(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFFF);
    send_item(FUNC_UNUSED, $urandom);
    send_item(fbpa_pkg::FUNC_ALLOC, $urandom);
    send_item(fbpa_pkg::FUNC_FREE, lbase);
    settle();
  endtask

  // Phases that lean toward allocate or toward free, so the pool swings
  // between empty and all free; registers rewritten between phases
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned plen;
    int unsigned pct;
    int unsigned roll;
    int unsigned k;
    int unsigned pos;
    int unsigned phase;
    logic [fbpa_pkg::ADDR_W-1:0] a;
    logic [fbpa_pkg::REG_W-1:0]  ridx;
    logic [fbpa_pkg::CFG_W-1:0]  rval;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      plen = $urandom_range(10, 60);
      pct  = (phase % 2 == 0) ? 75 : 25;
      for (int j = 0; j < plen; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          send_item(fbpa_pkg::FUNC_INIT, $urandom);
        end else if (roll < 5) begin
          send_item(FUNC_UNUSED, $urandom);
        end else if (roll < 5 + pct * 95 / 100) begin
          send_item(fbpa_pkg::FUNC_ALLOC, $urandom);
        end else begin
          k = $urandom_range(0, 99);
          if (k < 55 && live_blocks.size() != 0) begin
            pos = $urandom_range(0, live_blocks.size() - 1);
            a = live_blocks[pos];
            live_blocks.delete(pos);
          end else if (k < 70) begin
            a = lbase + $urandom_range(0, lcount - 1) * rsize;
          end else if (k < 78) begin
            a = lbase + $urandom_range(0, lcount - 1) * rsize + $urandom_range(1, rsize - 1);
          end else if (k < 83) begin
            a = lbase + $urandom_range(lcount, lcount + 300) * rsize;
          end else if (k < 86) begin
            a = lbase - $urandom_range(1, 4) * rsize;
          end else if (k < 91) begin
            a = '0;
          end else begin
            a = $urandom;
          end
          send_item(fbpa_pkg::FUNC_FREE, a);
        end
        sent++;
      end
      settle();
      ridx = fbpa_pkg::REG_W'($urandom_range(0, 2));
      case (ridx)
        fbpa_pkg::REG_POOL_BASE: begin
          rval = $urandom;
        end
        fbpa_pkg::REG_BLOCK_BYTES: begin
          rval = ($urandom_range(0, 1) == 0) ? 32'd8191 : $urandom_range(0, 4096);
        end
        default: begin
          rval = ($urandom_range(0, 1) == 0) ? 32'd511 : $urandom_range(0, 256);
        end
      endcase
      write_reg(ridx, rval);
      phase++;
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    func       = fbpa_pkg::FUNC_INIT;
    block_addr = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = fbpa_pkg::REG_POOL_BASE;
    cfg_wdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_before_init();
    test_init_and_repeat();
    test_directed_ops();
    test_random_traffic();

    // Drain, then watch for stray beats
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
